// ----- sv/tilt_pid_bidirectional_pwm_top_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef TILT_PID_BIDIRECTIONAL_PWM_TOP_MACROS_SVH
`define TILT_PID_BIDIRECTIONAL_PWM_TOP_MACROS_SVH
`ifndef SYNTH
`define TPP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TPP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TPP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/tpp_pkg.sv -----
`default_nettype none
package tpp_pkg;

  localparam int PwmWrapDef     = 5000;
  localparam int FracBitsDef    = 15;
  localparam int SmoothShiftDef = 6;
  localparam int DutyW          = 13;
  localparam int CfgIdxW        = 3;
  localparam int CfgDataW       = 31;

  localparam logic [CfgIdxW-1:0] REG_GAIN_P = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GAIN_I = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN_D = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ILIM   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TSTEP  = 3'd4;

  typedef struct packed {
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] gyro_z;
  } in_item_t;

  typedef struct packed {
    logic [DutyW-1:0]   forward_duty;
    logic [DutyW-1:0]   reverse_duty;
    logic               direction;
    logic signed [31:0] filtered_angle;
    logic [DutyW-1:0]   smoothed_drive;
    logic               divide_fault;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_GYRO, ST_ACC, ST_ACC2, ST_FILT1, ST_FILT2, ST_ERR,
    ST_PIDP, ST_PIDI, ST_PIDD, ST_DUTY, ST_OUT
  } state_t;

  // Handshake between sequencer and the divider.
  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ----- sv/tpp_if.sv -----
`default_nettype none
interface tpp_in_if;
  logic valid;
  logic ready;
  tpp_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tpp_out_if;
  logic valid;
  logic ready;
  tpp_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/tpp_div.sv -----
`default_nettype none
`include "tilt_pid_bidirectional_pwm_top_macros.svh"
module tpp_div #(
  parameter int FracBits = tpp_pkg::FracBitsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] num,
  input  wire logic signed [31:0] den,
  output logic                    busy,
  output logic signed [31:0]      quot
);
  import tpp_pkg::*;

  localparam int NW = 32 + FracBits;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic [31:0]   d_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [33:0]   trial;
  logic [NW:0]   qs;

  // One restoring step per cycle on the magnitudes.
  always_comb begin
    trial   = {rem_r, q_r[NW-1]} - {2'b0, d_r};
    rem_nxt = rem_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (cnt_r != '0) begin
      if (!trial[33]) begin
        rem_nxt = trial[32:0];
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], q_r[NW-1]};
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(NW);
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= NW'(num[31] ? -{{FracBits{num[31]}}, num} : {{FracBits{1'b0}}, num})
               << FracBits;
      rem_r <= '0;
      d_r   <= den[31] ? 32'(-den) : den;
      neg_r <= num[31] ^ den[31];
    end else begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = (cnt_r != '0);
  assign qs   = neg_r ? -{1'b0, q_r} : {1'b0, q_r};
  assign quot = sat32(66'($signed(qs)));

  `TPP_ASSERT_NEXT(a_div_count, clk, rst_n, start, busy)
  `TPP_ASSERT_NEXT(a_div_down, clk, rst_n, busy && !start, cnt_r == $past(cnt_r) - CW'(1))
  `TPP_ASSERT_IMPL(a_div_nostart, clk, rst_n, busy, !start)
endmodule
`default_nettype wire

// ----- sv/tilt_pid_bidirectional_pwm_top.sv -----
// Channel  | Dir | Payload
// in       | in  | accel_x, accel_y, gyro_z (signed fix15)
// out      | out | forward/reverse duty, direction, angle, smoothed drive, fault
// cfg      | in  | cfg_we, cfg_index, cfg_data
// After a request is accepted the divider is started and runs 47 restoring steps
// (32+FRAC_BITS); the sequencer then takes ten steps, the multiplying ones on the
// one shared 32x33 multiplier, before the result is presented.
// A new request is not accepted until the result has been taken.
// Reset clears the filter state and loads the register defaults.
// in_ready is low from acceptance until the sequencer is back in idle after the result has been taken.
`default_nettype none
`include "tilt_pid_bidirectional_pwm_top_macros.svh"
module tilt_pid_bidirectional_pwm_top #(
  parameter int PWM_WRAP     = tpp_pkg::PwmWrapDef,
  parameter int FRAC_BITS    = tpp_pkg::FracBitsDef,
  parameter int SMOOTH_SHIFT = tpp_pkg::SmoothShiftDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  tpp_in_if.sink                             in_ch,
  tpp_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [tpp_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [tpp_pkg::CfgDataW-1:0]  cfg_data
);
  import tpp_pkg::*;

  localparam logic signed [32:0] KP001 = 33'((64'sd1 <<< FRAC_BITS) / 1000);
  localparam logic signed [32:0] KP999 = 33'(((64'sd1 <<< FRAC_BITS) * 999) / 1000);
  localparam logic signed [32:0] KR2D  =
    33'(((64'sd1 <<< FRAC_BITS) * 64'sd57295779513) / 64'sd1000000000);

  // Configuration registers.
  logic [15:0] gain_p_r, gain_i_r, gain_d_r, tstep_r;
  logic [30:0] ilim_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= 16'd600;
      gain_i_r <= 16'd2;
      gain_d_r <= 16'd9000;
      ilim_r   <= 31'd81920000;
      tstep_r  <= 16'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_P: gain_p_r <= cfg_data[15:0];
        REG_GAIN_I: gain_i_r <= cfg_data[15:0];
        REG_GAIN_D: gain_d_r <= cfg_data[15:0];
        REG_ILIM:   ilim_r   <= cfg_data;
        REG_TSTEP:  tstep_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  state_t state_r, state_nxt;
  logic signed [31:0] ax_r, ay_r, gz_r;
  logic signed [31:0] angle_r, target_r, lasterr_r, esum_r;
  logic [DutyW-1:0]   avg_r;
  logic signed [31:0] gd_r, t0_r, err_r, deriv_r;
  logic signed [49:0] pid_r;
  logic               fault_r;
  out_item_t          res_r;
  logic               ovalid_r;
  div_ctl_t           dctl;
  logic signed [31:0] quot;

  tpp_div #(.FracBits(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dctl.start), .num(ax_r), .den(ay_r),
    .busy(dctl.busy), .quot(quot)
  );

  // Shared multiplier: operands chosen by state.
  logic signed [31:0] ma;
  logic signed [32:0] mb;
  logic signed [64:0] prod;
  logic signed [31:0] fxres;
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_r)
      ST_GYRO:  begin ma = gz_r; mb = KP001; end
      ST_ACC:   begin ma = fault_r ? (ax_r[31] ? 32'sh80000000 :
                         (ax_r == 0 ? 32'sd0 : 32'sh7fffffff)) : quot; mb = KR2D; end
      ST_FILT1: begin ma = t0_r; mb = KP001; end
      ST_FILT2: begin ma = sat32(66'(angle_r) - 66'(gd_r)); mb = KP999; end
      ST_PIDP:  begin ma = err_r; mb = 33'($signed({1'b0, gain_p_r})); end
      ST_PIDI:  begin ma = esum_r; mb = 33'($signed({1'b0, gain_i_r})); end
      ST_PIDD:  begin ma = deriv_r; mb = 33'($signed({1'b0, gain_d_r})); end
      default: ;
    endcase
  end
  assign prod  = 65'(ma) * 65'(mb);
  assign fxres = sat32(66'(prod >>> FRAC_BITS));

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_ch.valid) state_nxt = ST_DIV;
      ST_DIV:   if (!dctl.busy && !dctl.start) state_nxt = ST_GYRO;
      ST_GYRO:  state_nxt = ST_ACC;
      ST_ACC:   state_nxt = ST_ACC2;
      ST_ACC2:  state_nxt = ST_FILT1;
      ST_FILT1: state_nxt = ST_FILT2;
      ST_FILT2: state_nxt = ST_ERR;
      ST_ERR:   state_nxt = ST_PIDP;
      ST_PIDP:  state_nxt = ST_PIDI;
      ST_PIDI:  state_nxt = ST_PIDD;
      ST_PIDD:  state_nxt = ST_DUTY;
      ST_DUTY:  state_nxt = ST_OUT;
      ST_OUT:   if (!ovalid_r) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Output decode.
  logic start_q_r;
  always_comb begin
    dctl.start  = start_q_r;
    in_ch.ready = (state_r == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      start_q_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      start_q_r <= (state_r == ST_IDLE) && in_ch.valid;
    end
  end

  // Datapath.
  logic signed [31:0] err_c, es_c;
  logic signed [65:0] lim_c;
  logic signed [49:0] drive;
  logic [49:0]        mag;
  logic [DutyW-1:0]   duty;
  logic signed [DutyW+1:0] dif;
  always_comb begin
    err_c = sat32(66'(target_r) - 66'(angle_r));
    es_c  = sat32(66'(esum_r) + 66'(err_c));
    lim_c = 66'($signed({1'b0, ilim_r}));
    if (66'(es_c) > lim_c) es_c = 32'(lim_c);
    else if (66'(es_c) < -lim_c) es_c = 32'(-lim_c);
    drive = pid_r[49] ? -((-pid_r) >>> FRAC_BITS) : (pid_r >>> FRAC_BITS);
    mag   = drive[49] ? 50'(-drive) : 50'(drive);
    duty  = (mag > 50'(PWM_WRAP)) ? DutyW'(PWM_WRAP) : DutyW'(mag);
    dif   = $signed({2'b0, duty}) - $signed({2'b0, avg_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0; target_r <= '0; lasterr_r <= '0; esum_r <= '0; avg_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: if (in_ch.valid) begin
          ax_r <= in_ch.data.accel_x; ay_r <= in_ch.data.accel_y;
          gz_r <= in_ch.data.gyro_z; fault_r <= (in_ch.data.accel_y == 0);
        end
        ST_GYRO:  gd_r <= fxres;
        ST_ACC:   t0_r <= sat32(-66'(fxres));
        ST_FILT1: t0_r <= fxres;
        ST_FILT2: angle_r <= sat32(66'(fxres) + 66'(t0_r));
        ST_ERR: begin
          err_r     <= err_c;
          deriv_r   <= sat32(66'(err_c) - 66'(lasterr_r));
          esum_r    <= es_c;
          lasterr_r <= err_c;
          target_r  <= err_c[31] ? sat32(66'(target_r) - 66'(tstep_r))
                                 : sat32(66'(target_r) + 66'(tstep_r));
        end
        ST_PIDP:  pid_r <= 50'(prod);
        ST_PIDI, ST_PIDD: pid_r <= pid_r + 50'(prod);
        ST_DUTY: begin
          res_r.direction      <= !(pid_r > 0);
          res_r.forward_duty   <= (pid_r > 0) ? duty : '0;
          res_r.reverse_duty   <= (pid_r > 0) ? '0 : duty;
          res_r.filtered_angle <= angle_r;
          res_r.smoothed_drive <= DutyW'($signed({avg_r[DutyW-1], avg_r}) +
                                  (dif >>> SMOOTH_SHIFT));
          res_r.divide_fault   <= fault_r;
          avg_r <= DutyW'($signed({1'b0, avg_r}) + (dif >>> SMOOTH_SHIFT));
          ovalid_r <= 1'b1;
        end
        ST_OUT: if (out_ch.ready) ovalid_r <= 1'b0;
        default: ;
      endcase
    end
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = res_r;

  `TPP_ASSERT_IMPL(a_busy_noready, clk, rst_n, state_r != ST_IDLE, !in_ch.ready)
  `TPP_ASSERT_IMPL(a_valid_in_out, clk, rst_n, ovalid_r, state_r == ST_OUT)
  `TPP_ASSERT_IMPL(a_duty_excl, clk, rst_n, ovalid_r,
                   res_r.forward_duty == 0 || res_r.reverse_duty == 0)
endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tpp_pkg::*;

  localparam int      Frac      = FracBitsDef;
  localparam longint  OneFx     = longint'(1) << Frac;
  localparam longint  KMilli    = (OneFx * 1) / 1000;
  localparam longint  KKeep     = (OneFx * 999) / 1000;
  localparam longint  KRadToDeg = (OneFx * 64'sd57295779513) / 64'sd1000000000;
  localparam longint  Int32Max  = 64'sd2147483647;
  localparam longint  Int32Min  = -64'sd2147483648;
  localparam int      IdlePct   = 32;
  localparam int      HoldLen   = 400;
  localparam int      SettleLen = 80;
  localparam int      StallLimit = 6000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  tpp_in_if  in_if ();
  tpp_out_if out_if ();

  tilt_pid_bidirectional_pwm_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock with a 12 ns period.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Controller registers as the block should hold them.
  longint kp, ki, kd, int_limit, step_size;
  // Filter and controller state.
  longint angle_est, target, prev_err, err_sum, avg_duty;

  in_item_t  pending_samples[$];
  out_item_t expected_outputs[$];
  int        mismatches;
  bit        calm;
  bit        sample_taken;
  int        hold_requests;
  int        quiet_cycles;

  function automatic longint clamp32(longint v);
    if (v > Int32Max) return Int32Max;
    if (v < Int32Min) return Int32Min;
    return v;
  endfunction

  // Fixed-point product, rounded toward minus infinity.
  function automatic longint fx_product(longint a, longint b);
    return clamp32((a * b) >>> Frac);
  endfunction

  // Steps the filter and PID for one sample and returns the result it should give.
  function automatic out_item_t control_step(in_item_t s);
    longint ax, ay, gz, quot, gyro_inc, acc_angle, err, deriv, pid, drv, mag, duty;
    out_item_t r;
    ax = s.accel_x;
    ay = s.accel_y;
    gz = s.gyro_z;
    r = '0;
    if (ay == 0) begin
      r.divide_fault = 1'b1;
      quot = (ax > 0) ? Int32Max : ((ax < 0) ? Int32Min : 0);
    end else begin
      quot = clamp32((ax * OneFx) / ay);
    end
    gyro_inc  = fx_product(gz, KMilli);
    acc_angle = clamp32(-fx_product(quot, KRadToDeg));
    angle_est = clamp32(fx_product(clamp32(angle_est - gyro_inc), KKeep)
                        + fx_product(acc_angle, KMilli));
    err = clamp32(target - angle_est);
    if (err < 0) target = clamp32(target - step_size);
    else target = clamp32(target + step_size);
    deriv = clamp32(err - prev_err);
    err_sum = clamp32(err_sum + err);
    if (err_sum > int_limit) err_sum = int_limit;
    else if (err_sum < -int_limit) err_sum = -int_limit;
    prev_err = err;
    pid = kp * err + ki * err_sum + kd * deriv;
    drv = pid / OneFx;
    mag = (drv < 0) ? -drv : drv;
    duty = (mag > PwmWrapDef) ? PwmWrapDef : mag;
    if (pid > 0) begin
      r.direction = 1'b0;
      r.forward_duty = duty[DutyW-1:0];
    end else begin
      r.direction = 1'b1;
      r.reverse_duty = duty[DutyW-1:0];
    end
    avg_duty = avg_duty + ((duty - avg_duty) >>> SmoothShiftDef);
    r.smoothed_drive = avg_duty[DutyW-1:0];
    r.filtered_angle = angle_est[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    mismatches++;
    $display("error: %s got %0d, want %0d", field, got, want);
  endtask

  // Request driver: holds a request until it is taken, then picks the next.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || sample_taken) begin
      if (pending_samples.size() == 0 || (!calm && $urandom_range(99) < IdlePct)) begin
        in_if.valid <= 1'b0;
      end else begin
        in_if.valid <= 1'b1;
        in_if.data  <= pending_samples.pop_front();
      end
    end
  end

  // Result receiver, with random stalls and an occasional long hold-off.
  int hold_left = 0;
  int holds_seen = 0;
  always @(negedge clk) begin
    if (hold_requests != holds_seen) begin
      holds_seen = hold_requests;
      hold_left = HoldLen;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  // Monitor: predicts on every accepted request and checks every result.
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    sample_taken = rst_n && in_if.valid && in_if.ready;
    if (sample_taken) expected_outputs.push_back(control_step(in_if.data));
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (expected_outputs.size() == 0) begin
        mismatches++;
        $display("error: result with nothing expected");
      end else begin
        want = expected_outputs.pop_front();
        if (got.forward_duty != want.forward_duty)
          report_mismatch("forward_duty", got.forward_duty, want.forward_duty);
        if (got.reverse_duty != want.reverse_duty)
          report_mismatch("reverse_duty", got.reverse_duty, want.reverse_duty);
        if (got.direction != want.direction)
          report_mismatch("direction", got.direction, want.direction);
        if (got.filtered_angle != want.filtered_angle)
          report_mismatch("filtered_angle", got.filtered_angle, want.filtered_angle);
        if (got.smoothed_drive != want.smoothed_drive)
          report_mismatch("smoothed_drive", got.smoothed_drive, want.smoothed_drive);
        if (got.divide_fault != want.divide_fault)
          report_mismatch("divide_fault", got.divide_fault, want.divide_fault);
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("tilt_pid_bidirectional_pwm_top: mismatch");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_GAIN_P: kp        = value[15:0];
      REG_GAIN_I: ki        = value[15:0];
      REG_GAIN_D: kd        = value[15:0];
      REG_ILIM:   int_limit = value[30:0];
      REG_TSTEP:  step_size = value[15:0];
      default: ;
    endcase
  endtask

  task automatic add_sample(logic [31:0] ax, logic [31:0] ay, logic [31:0] gz);
    in_item_t s;
    s.accel_x = ax;
    s.accel_y = ay;
    s.gyro_z  = gz;
    pending_samples.push_back(s);
  endtask

  // Mostly plausible IMU readings, with some raw noise and zero divisors.
  task automatic add_random(int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 70)
        add_sample($signed($urandom_range(65536)) - 32768,
                   $signed($urandom_range(65536)) - 32768 + 4,
                   $signed($urandom_range(8000000)) - 4000000);
      else if (pick < 80)
        add_sample($urandom(), 32'd0, $urandom());
      else
        add_sample($urandom(), $urandom(), $urandom());
    end
  endtask

  // Waits until every request has been answered and the block has settled.
  task automatic drain();
    while (pending_samples.size() != 0 || in_if.valid || expected_outputs.size() != 0)
      @(posedge clk);
    repeat (SettleLen) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    mismatches = 0;
    calm = 1'b0;
    sample_taken = 1'b0;
    hold_requests = 0;
    quiet_cycles = 0;
    kp = 600; ki = 2; kd = 9000; int_limit = 81920000; step_size = 3;
    angle_est = 0; target = 0; prev_err = 0; err_sum = 0; avg_duty = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed samples under the reset settings: field extremes and zero divisors.
    add_sample(32'sh7fffffff, 32'sd1, 32'sd0);
    add_sample(32'sh80000000, 32'sd1, 32'sd0);
    add_sample(32'sh80000000, 32'shffffffff, 32'sh7fffffff);
    add_sample(32'sd1000, 32'sd0, 32'sd0);
    add_sample(-32'sd1000, 32'sd0, 32'sh80000000);
    add_sample(32'sd0, 32'sd0, 32'sd0);
    add_sample(32'sd0, 32'sh7fffffff, 32'sh7fffffff);
    add_sample(32'sd0, 32'sh80000000, 32'sh80000000);
    add_sample(32'sd1, 32'sh7fffffff, 32'sd1);
    add_sample(32'sd16384, 32'sd32768, -32'sd50000);
    add_sample(-32'sd16384, 32'sd32768, 32'sd50000);
    add_sample(32'sd0, 32'sd32768, 32'sd0);
    add_sample(32'sd3, 32'sd32768, 32'sd0);
    add_sample(32'shffffffff, 32'shffffffff, 32'shffffffff);
    add_sample(32'sh55555555, 32'shaaaaaaaa, 32'sh55555555);
    add_sample(32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa);
    add_random(150);
    drain();

    // Largest settings, with a long receiver hold-off to back up the input.
    write_reg(REG_GAIN_P, '1);
    write_reg(REG_GAIN_I, '1);
    write_reg(REG_GAIN_D, '1);
    write_reg(REG_ILIM, '1);
    write_reg(REG_TSTEP, '1);
    hold_requests++;
    add_random(150);
    drain();

    // All-zero settings, run without any idling.
    write_reg(REG_GAIN_P, '0);
    write_reg(REG_GAIN_I, '0);
    write_reg(REG_GAIN_D, '0);
    write_reg(REG_ILIM, '0);
    write_reg(REG_TSTEP, '0);
    calm = 1'b1;
    add_random(150);
    drain();
    calm = 1'b0;

    // Random settings with wide data and writes to unused indexes.
    write_reg(REG_GAIN_P, CfgDataW'($urandom()));
    write_reg(REG_GAIN_I, CfgDataW'($urandom_range(20)));
    write_reg(REG_GAIN_D, CfgDataW'($urandom()));
    write_reg(REG_ILIM, CfgDataW'($urandom()));
    write_reg(REG_TSTEP, CfgDataW'($urandom()));
    write_reg(3'd5, CfgDataW'($urandom()));
    write_reg(3'd6, CfgDataW'($urandom()));
    write_reg(3'd7, CfgDataW'($urandom()));
    add_random(150);
    drain();

    if (mismatches == 0 && expected_outputs.size() == 0) begin
      $display("tilt_pid_bidirectional_pwm_top: match");
    end else begin
      $display("tilt_pid_bidirectional_pwm_top: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- tilt_pid_bidirectional_pwm_top.f -----
+incdir+sv
sv/tpp_pkg.sv
sv/tpp_if.sv
sv/tpp_div.sv
sv/tilt_pid_bidirectional_pwm_top.sv
verif/testbench.sv
